>>> rtl/wrt_pkg.sv
// Package for the write region tracker: field widths, request and outcome codes,
// and the item token that travels along the chain of region cells.
// Depends on nothing; every other file in rtl imports it.
package wrt_pkg;

   localparam int MaxRegionsDefault = 64;
   localparam int AddrW             = 32;
   localparam int UsedW             = 7;
   localparam int ReqTdataW         = 64;
   localparam int RspTdataW         = 48;
   localparam int RspPadW           = RspTdataW - (AddrW + UsedW + 2 + 1);

   typedef enum logic {
      REQ_TRACK = 1'b0,
      REQ_QUERY = 1'b1
   } req_kind_type;

   typedef enum logic [1:0] {
      OUTCOME_MERGED  = 2'd0,
      OUTCOME_ADDED   = 2'd1,
      OUTCOME_FULL    = 2'd2,
      OUTCOME_IGNORED = 2'd3
   } outcome_type;

   typedef struct packed {
      logic               valid;
      logic               is_query;
      logic               done;
      logic               hit;
      outcome_type        outcome;
      logic [AddrW-1:0]   addr;
      logic [AddrW-1:0]   end_addr;
      logic [AddrW-1:0]   total;
   } tok_type;

endpackage

>>> rtl/wrt_cell.sv
// One region cell: holds one [start, end) range and the token register that hands
// the item on to the next cell. Depends on wrt_pkg.
module wrt_cell
   import wrt_pkg::*;
#(
   parameter int INDEX   = 0,
   parameter int COUNT_W = 7
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  logic [COUNT_W-1:0] count,
   input  tok_type            tok_in,
   output tok_type            tok_out,
   output logic               append
);

   localparam logic [COUNT_W-1:0] MyIndex = COUNT_W'(INDEX);

   logic [AddrW-1:0] start_ff, start_in;
   logic [AddrW-1:0] end_ff, end_in;
   tok_type          tok_ff, tok_in_next;
   logic             region_valid;
   logic             touches;
   logic             claim;
   logic             merge;
   logic             covers;

   always_comb begin
      region_valid = MyIndex < count;
      touches      = (tok_in.addr <= end_ff) && (tok_in.end_addr >= start_ff);
      claim        = tok_in.valid && !tok_in.is_query && !tok_in.done;
      merge        = claim && region_valid && touches;
      append       = advance && claim && !merge && (count == MyIndex);
      covers       = region_valid && (tok_in.addr >= start_ff) && (tok_in.addr < end_ff);

      start_in = start_ff;
      end_in   = end_ff;
      if (append) begin
         start_in = tok_in.addr;
         end_in   = tok_in.end_addr;
      end else if (merge) begin
         if (tok_in.addr < start_ff) begin
            start_in = tok_in.addr;
         end
         if (tok_in.end_addr > end_ff) begin
            end_in = tok_in.end_addr;
         end
      end

      tok_in_next = tok_in;
      if (merge) begin
         tok_in_next.done    = 1'b1;
         tok_in_next.outcome = OUTCOME_MERGED;
      end else if (append) begin
         tok_in_next.done    = 1'b1;
         tok_in_next.outcome = OUTCOME_ADDED;
      end
      if (tok_in.is_query && covers) begin
         tok_in_next.hit = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         start_ff <= start_in;
         end_ff   <= end_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else if (advance) begin
         tok_ff <= tok_in_next;
      end
   end

   assign tok_out = tok_ff;

endmodule

>>> rtl/write_region_tracker_core.sv
// Top level of the write region tracker: entry stage, the chain of region cells and
// the result register. Depends on wrt_pkg and wrt_cell.
//
//   Channel  Direction  Payload
//   req_     in         tuser: req_type; tdata: addr, size
//   rsp_     out        tdata: written_hit, track_outcome, regions_used, total_bytes
//
// An item is loaded into the entry register at the edge that accepts it, then moves
// one cell per cycle while the chain advances and then into the result register,
// from which its result is offered.
// The chain is a pipeline: one item is accepted per cycle while rsp_tready is high.
// When a result waits at the output, the whole chain holds and req_tready falls.
// Reset empties the chain and clears the region count and the byte total.
module write_region_tracker_core
   import wrt_pkg::*;
#(
   parameter int MAX_REGIONS = MaxRegionsDefault
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [ReqTdataW-1:0] req_tdata,   // addr[31:0], size[63:32]
   input  logic                 req_tuser,   // req_type
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [RspTdataW-1:0] rsp_tdata    // written_hit, track_outcome[2:1],
                                             // regions_used[9:3], total_bytes[41:10]
);

   localparam int CountW = $clog2(MAX_REGIONS + 1);

   logic                 advance;
   logic                 accept;
   logic [AddrW-1:0]     req_addr;
   logic [AddrW-1:0]     req_size;
   logic                 counted;

   logic [AddrW-1:0]     total_ff, total_in;
   logic [CountW-1:0]    count_ff, count_in;
   logic [CountW-1:0]    exit_count_ff, exit_count_in;
   tok_type              entry_ff, entry_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [RspTdataW-1:0] rsp_data_ff, rsp_data_in;

   tok_type              chain_tok [MAX_REGIONS+1];
   logic [MAX_REGIONS-1:0] append_vec;
   tok_type              last_tok;
   outcome_type          last_outcome;
   logic [CountW-1:0]    used_after;

   assign advance  = !rsp_valid_ff || rsp_tready;
   assign accept   = req_tvalid && advance;
   assign req_addr = req_tdata[AddrW-1:0];
   assign req_size = req_tdata[2*AddrW-1:AddrW];
   assign counted  = (req_kind_type'(req_tuser) == REQ_TRACK) && (req_size != '0);

   always_comb begin
      total_in = total_ff;
      if (accept && counted) begin
         total_in = total_ff + req_size;
      end

      entry_in          = entry_ff;
      entry_in.valid    = accept;
      entry_in.is_query = req_kind_type'(req_tuser) == REQ_QUERY;
      entry_in.done     = !counted;
      entry_in.hit      = 1'b0;
      entry_in.outcome  = counted ? OUTCOME_FULL : OUTCOME_IGNORED;
      entry_in.addr     = req_addr;
      entry_in.end_addr = req_addr + req_size;
      entry_in.total    = total_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff       <= '0;
         entry_ff.valid <= 1'b0;
      end else if (advance) begin
         total_ff <= total_in;
         entry_ff <= entry_in;
      end
   end

   assign chain_tok[0] = entry_ff;

   for (genvar i = 0; i < MAX_REGIONS; i++) begin : g_cell
      wrt_cell #(
         .INDEX   (i),
         .COUNT_W (CountW)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .count   (count_ff),
         .tok_in  (chain_tok[i]),
         .tok_out (chain_tok[i+1]),
         .append  (append_vec[i])
      );
   end

   assign count_in = count_ff + CountW'(|append_vec);
   assign last_tok = chain_tok[MAX_REGIONS];

   always_comb begin
      last_outcome  = last_tok.outcome;
      used_after    = exit_count_ff;
      if (last_tok.outcome == OUTCOME_ADDED) begin
         used_after = exit_count_ff + CountW'(1);
      end
      exit_count_in = exit_count_ff;
      if (last_tok.valid) begin
         exit_count_in = used_after;
      end
      rsp_valid_in = last_tok.valid;
      rsp_data_in  = {{RspPadW{1'b0}}, last_tok.total, UsedW'(used_after),
                      last_outcome, last_tok.hit};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         exit_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else if (advance) begin
         count_ff      <= count_in;
         exit_count_ff <= exit_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign req_tready = advance;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

>>> rtl/wrt_checker.sv
// Port-level checks for the write region tracker, and the bind that attaches them
// to write_region_tracker_core. Depends on wrt_pkg.
module wrt_checker
   import wrt_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 req_tready,
   input logic                 rsp_tvalid,
   input logic                 rsp_tready,
   input logic [RspTdataW-1:0] rsp_tdata
);

   // After reset no result is on offer.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result offered straight after reset");

   // A waiting result keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled result changed");

   // A hit can only come from a query, whose outcome is always ignored.
   a_hit_query: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[0]) |-> (rsp_tdata[2:1] == OUTCOME_IGNORED))
      else $error("hit reported with a track outcome");

   // With the output register empty the block must take a new item.
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled while output is empty");

endmodule

bind write_region_tracker_core wrt_checker u_wrt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
